// ----- sv/udiv_pkg.sv -----
`timescale 1ns / 1ps

package udiv_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DRAIN
  } udiv_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } udiv_seq_t;

  typedef struct packed {
    logic load;
    logic step;
    logic ge;
  } udiv_cell_ctl_t;

endpackage

// ----- sv/udiv_cell.sv -----
`timescale 1ns / 1ps

module udiv_cell (
  input  logic                     clk,
  input  udiv_pkg::udiv_cell_ctl_t ctl,
  input  logic                     num_bit,
  input  logic                     den_bit,
  input  logic                     rem_in,
  input  logic                     quo_in,
  input  logic                     borrow_in,
  output logic                     rem_out,
  output logic                     quo_out,
  output logic                     borrow_out
);
  import udiv_pkg::*;

  logic rem_r;
  logic rem_nxt;
  logic quo_r;
  logic quo_nxt;
  logic den_r;
  logic den_nxt;
  logic diff;

  // one bit of the trial subtraction on the shifted remainder
  assign diff       = rem_in ^ den_r ^ borrow_in;
  assign borrow_out = (~rem_in & den_r) | (~(rem_in ^ den_r) & borrow_in);

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    if (ctl.load) begin
      rem_nxt = 1'b0;
      quo_nxt = num_bit;
      den_nxt = den_bit;
    end else if (ctl.step) begin
      rem_nxt = ctl.ge ? diff : rem_in;
      quo_nxt = quo_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rem_out = rem_r;
  assign quo_out = quo_r;

endmodule

// ----- sv/udiv_ctrl.sv -----
`timescale 1ns / 1ps

module udiv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output udiv_pkg::udiv_seq_t seq
);
  import udiv_pkg::*;

  udiv_state_t      state_r;
  udiv_state_t      state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             slot_free;

  assign slot_free = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_BUSY;
      ST_BUSY:  if (cnt_r == '0) state_nxt = ST_DRAIN;
      ST_DRAIN: if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    seq.load    = 1'b0;
    seq.step    = 1'b0;
    seq.capture = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        seq.load = in_valid;
      end
      ST_BUSY:  seq.step = 1'b1;
      ST_DRAIN: seq.capture = slot_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (seq.load) begin
      cnt_nxt = CNT_W'(DATA_WIDTH - 1);
    end else if (seq.step) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (seq.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_capture_slot: assert property (@(posedge clk) disable iff (!rst_n)
    seq.capture |-> (!out_valid_r || out_ready))
    else $error("result captured over an untaken beat");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY && cnt_r == '0) |=> (state_r == ST_DRAIN))
    else $error("divider did not finish after last step");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    seq.load |=> (state_r == ST_BUSY && cnt_r == CNT_W'(DATA_WIDTH - 1)))
    else $error("step count not started on accepted beat");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (seq.step || seq.capture) |-> !in_ready)
    else $error("input taken while an item is in flight");

endmodule

// ----- sv/unsigned_divide_64.sv -----
`timescale 1ns / 1ps
// channel  | ports                                    | dir
// ---------+------------------------------------------+-----
// input    | in_valid, in_ready, in_dividend, in_divisor | in
// result   | out_valid, out_ready, out_quotient, out_remainder | out
//
// one item goes through accept, 64 restoring steps through the cell row, then capture
// each step shifts remainder and quotient one cell along and subtracts across the row
// a zero divisor yields an all-ones quotient and the dividend as remainder
// a new beat is taken while the previous result waits in the output register
// a stalled result holds the row after its last step until the output register frees
// synchronous active-low reset clears control only

module unsigned_divide_64 (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [udiv_pkg::DATA_WIDTH-1:0] in_dividend,
  input  logic [udiv_pkg::DATA_WIDTH-1:0] in_divisor,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [udiv_pkg::DATA_WIDTH-1:0] out_quotient,
  output logic [udiv_pkg::DATA_WIDTH-1:0] out_remainder
);
  import udiv_pkg::*;

  udiv_seq_t             seq;
  udiv_cell_ctl_t        ctl;
  logic [DATA_WIDTH-1:0] rem_w;
  logic [DATA_WIDTH-1:0] quo_w;
  logic [DATA_WIDTH-1:0] borrow_w;
  logic [DATA_WIDTH-1:0] quotient_r;
  logic [DATA_WIDTH-1:0] quotient_nxt;
  logic [DATA_WIDTH-1:0] remainder_r;
  logic [DATA_WIDTH-1:0] remainder_nxt;

  udiv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .seq       (seq)
  );

  // shifted remainder fits the divisor if its carried-out top bit is set or no borrow
  assign ctl.load = seq.load;
  assign ctl.step = seq.step;
  assign ctl.ge   = rem_w[DATA_WIDTH-1] | ~borrow_w[DATA_WIDTH-1];

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    logic rem_in;
    logic quo_in;
    logic borrow_in;

    if (i == 0) begin : g_first
      assign rem_in    = quo_w[DATA_WIDTH-1];
      assign quo_in    = ctl.ge;
      assign borrow_in = 1'b0;
    end else begin : g_rest
      assign rem_in    = rem_w[i-1];
      assign quo_in    = quo_w[i-1];
      assign borrow_in = borrow_w[i-1];
    end

    udiv_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .num_bit    (in_dividend[i]),
      .den_bit    (in_divisor[i]),
      .rem_in     (rem_in),
      .quo_in     (quo_in),
      .borrow_in  (borrow_in),
      .rem_out    (rem_w[i]),
      .quo_out    (quo_w[i]),
      .borrow_out (borrow_w[i])
    );
  end

  always_comb begin
    quotient_nxt  = quotient_r;
    remainder_nxt = remainder_r;
    if (seq.capture) begin
      quotient_nxt  = quo_w;
      remainder_nxt = rem_w;
    end
  end

  always_ff @(posedge clk) begin
    quotient_r  <= quotient_nxt;
    remainder_r <= remainder_nxt;
  end

  assign out_quotient  = quotient_r;
  assign out_remainder = remainder_r;

endmodule

// ----- test/unsigned_divide_64_test.sv -----
`timescale 1ns / 1ps

module unsigned_divide_64_test;

  localparam int DW           = udiv_pkg::DATA_WIDTH;
  localparam int N_RANDOM     = 1500;
  localparam int N_DIRECTED   = 24;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int LIMIT_CYCLES = 2_000_000;

  localparam logic [DW-1:0] ONES = '1;
  localparam logic [DW-1:0] TOP  = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] ALT  = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef struct packed {
    logic [DW-1:0] quotient;
    logic [DW-1:0] remainder;
  } quot_rem_t;

  typedef struct packed {
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
    logic          typed;
    logic [DW-1:0] quotient;
    logic [DW-1:0] remainder;
  } div_row_t;

  localparam div_row_t DIV_ROWS [N_DIRECTED] = '{
    '{64'h0, 64'h0, 1'b1, ONES, 64'h0},
    '{ONES, 64'h0, 1'b1, ONES, ONES},
    '{64'h0123_4567_89AB_CDEF, 64'h0, 1'b1, ONES, 64'h0123_4567_89AB_CDEF},
    '{64'h0, 64'h1, 1'b1, 64'h0, 64'h0},
    '{ONES, 64'h1, 1'b1, ONES, 64'h0},
    '{ONES, ONES, 1'b1, 64'h1, 64'h0},
    '{64'h0, ONES, 1'b1, 64'h0, 64'h0},
    '{64'h1, ONES, 1'b1, 64'h0, 64'h1},
    '{64'hFFFF_FFFF_FFFF_FFFE, ONES, 1'b1, 64'h0, 64'hFFFF_FFFF_FFFF_FFFE},
    '{ONES, 64'h2, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1},
    '{TOP, TOP, 1'b1, 64'h1, 64'h0},
    '{ONES, TOP, 1'b1, 64'h1, 64'h7FFF_FFFF_FFFF_FFFF},
    '{TOP, 64'h1, 1'b1, TOP, 64'h0},
    '{64'h8000_0000_0000_0001, TOP, 1'b1, 64'h1, 64'h1},
    '{TOP, 64'h3, 1'b0, 64'h0, 64'h0},
    '{64'd100, 64'd7, 1'b1, 64'd14, 64'd2},
    '{64'd7, 64'd100, 1'b1, 64'h0, 64'd7},
    '{ALT, ~ALT, 1'b1, 64'h2, 64'h0},
    '{~ALT, ALT, 1'b1, 64'h0, ~ALT},
    '{ONES, 64'h3, 1'b1, 64'h5555_5555_5555_5555, 64'h0},
    '{ONES, 64'h0000_0000_FFFF_FFFF, 1'b1, 64'h0000_0001_0000_0001, 64'h0},
    '{64'hDEAD_BEEF_CAFE_F00D, 64'h0001_2345, 1'b0, 64'h0, 64'h0},
    '{64'h1, 64'h1, 1'b1, 64'h1, 64'h0},
    '{64'hFFFF_FFFF_0000_0000, 64'h1_0000_0000, 1'b1, 64'hFFFF_FFFF, 64'h0}
  };

  logic          clk;
  logic          rst_n         = 1'b0;
  logic          in_valid      = 1'b0;
  logic          in_ready;
  logic [DW-1:0] in_dividend   = '0;
  logic [DW-1:0] in_divisor    = '0;
  logic          out_valid;
  logic          out_ready     = 1'b0;
  logic [DW-1:0] out_quotient;
  logic [DW-1:0] out_remainder;

  quot_rem_t quot_rem_q [$];
  int        n_errors      = 0;
  int        n_sent        = 0;
  int        n_zero_div    = 0;
  int        n_checked     = 0;
  int        n_cycles      = 0;
  bit        long_hold_req = 1'b0;

  unsigned_divide_64 i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_dividend   (in_dividend),
    .in_divisor    (in_divisor),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_quotient  (out_quotient),
    .out_remainder (out_remainder)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               quot_rem_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // shift-and-subtract restoring division, zero divisor gives all ones
  function automatic quot_rem_t divide_restoring(input logic [DW-1:0] num_in,
                                                 input logic [DW-1:0] den_in);
    logic [DW-1:0] num;
    logic [DW-1:0] den;
    logic [DW-1:0] pos;
    logic [DW-1:0] quo;
    quot_rem_t     res;
    num = num_in;
    den = den_in;
    pos = DW'(1);
    quo = '0;
    if (den == '0) begin
      res.quotient  = ONES;
      res.remainder = num;
      return res;
    end
    while (den < num && !den[DW-1]) begin
      den = den << 1;
      pos = pos << 1;
    end
    while (pos != '0) begin
      if (num >= den) begin
        num = num - den;
        quo = quo | pos;
      end
      den = den >> 1;
      pos = pos >> 1;
    end
    res.quotient  = quo;
    res.remainder = num;
    return res;
  endfunction

  function automatic logic [DW-1:0] rand_operand();
    logic [DW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0:       v = '0;
      1:       v = $urandom_range(0, 1) ? ONES : TOP;
      2:       v = 64'h1 << $urandom_range(0, DW - 1);
      3:       v = DW'($urandom_range(0, 255));
      default: v = v >> $urandom_range(0, DW - 1);
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", n_cycles, what, got, want);
    n_errors++;
  endtask

  // beat stays offered until taken, expectation queued at the accepting edge
  task automatic send_division(input logic [DW-1:0] num, input logic [DW-1:0] den,
                               input logic typed, input quot_rem_t want);
    in_valid    <= 1'b1;
    in_dividend <= num;
    in_divisor  <= den;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    quot_rem_q.push_back(typed ? want : divide_restoring(num, den));
    n_sent++;
    if (den == '0) n_zero_div++;
  endtask

  always @(posedge clk) begin
    quot_rem_t want;
    if (rst_n && out_valid && out_ready) begin
      if (quot_rem_q.size() == 0) begin
        report_mismatch("result beat with nothing expected, quotient", out_quotient, 'x);
      end else begin
        want = quot_rem_q.pop_front();
        if (out_quotient !== want.quotient)
          report_mismatch("quotient", out_quotient, want.quotient);
        if (out_remainder !== want.remainder)
          report_mismatch("remainder", out_remainder, want.remainder);
        n_checked++;
      end
    end
  end

  initial begin
    int mode;
    int span;
    wait (rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          2:       out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [DW-1:0] num;
    logic [DW-1:0] den;
    int            burst;
    int            gap;
    int            idx;
    bit            paused;
    bit            pause_now;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_division(DIV_ROWS[i].dividend, DIV_ROWS[i].divisor, DIV_ROWS[i].typed,
                    '{DIV_ROWS[i].quotient, DIV_ROWS[i].remainder});
    end

    idx    = 0;
    paused = 1'b0;
    while (idx < N_RANDOM) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && idx < N_RANDOM) begin
        num = rand_operand();
        den = rand_operand();
        case ($urandom_range(0, 19))
          0:       den = num;
          1:       den = num + 1;
          2:       den = '0;
          default: ;
        endcase
        send_division(num, den, 1'b0, '0);
        idx++;
        burst--;
        if (idx == HOLD_AT) long_hold_req = 1'b1;
      end
      gap       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      pause_now = !paused && idx >= N_RANDOM / 2;
      if (pause_now && gap == 0) gap = 1;
      if (gap > 0) begin
        in_valid    <= 1'b0;
        in_dividend <= {$urandom, $urandom};
        in_divisor  <= {$urandom, $urandom};
      end
      if (pause_now) begin
        paused = 1'b1;
        while (quot_rem_q.size() != 0) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b0;

    while (quot_rem_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d divisions, %0d of them by zero, incl. extremes and back-pressure",
             n_sent, n_zero_div);
    $display("checked %0d results in %0d cycles, %0d mismatches", n_checked, n_cycles,
             n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
